FILE: src/tmc_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the model matrix composer.
// Used by every module in src; depends on nothing.
package tmc_pkg;

    localparam int SINCOS_ITERATIONS = 16;
    localparam int MAX_STEPS         = 24;
    localparam int N_STEPS           = (SINCOS_ITERATIONS > MAX_STEPS) ? MAX_STEPS
                                                                       : SINCOS_ITERATIONS;
    // stage 0 angle prep, N_STEPS cordic cells, post, two product stages, sum, output
    localparam int LAST              = N_STEPS + 5;
    localparam int STEP_W            = 5;

    typedef logic signed [33:0] cw_t;
    typedef logic signed [31:0] trig_t;
    typedef logic signed [32:0] rot_t;
    typedef logic signed [16:0] ang_t;

    localparam cw_t  CORDIC_GAIN  = 34'sd652032874;
    localparam cw_t  ONE_Q30      = 34'sd1073741824;
    localparam logic [39:0] DEG2RAD_Q32 = 40'd74961321;
    localparam ang_t FULL_TURN    = 17'sd23040;
    localparam ang_t HALF_TURN    = 17'sd11520;
    localparam ang_t QUARTER_TURN = 17'sd5760;

    typedef struct packed {
        logic neg;
        logic flip;
    } fold_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
        logic signed [23:0] scale_z;
        fold_t [2:0]        fold;
    } side_t;

    function automatic cw_t atan_q30(input logic [STEP_W-1:0] idx);
        cw_t v;
        unique case (idx)
            5'd0:    v = 34'sd843314856;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043836;
            5'd3:    v = 34'sd133525158;
            5'd4:    v = 34'sd67021686;
            5'd5:    v = 34'sd33543515;
            5'd6:    v = 34'sd16775850;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194282;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048575;
            5'd11:   v = 34'sd524287;
            5'd12:   v = 34'sd262143;
            5'd13:   v = 34'sd131071;
            5'd14:   v = 34'sd65535;
            5'd15:   v = 34'sd32767;
            5'd16:   v = 34'sd16383;
            5'd17:   v = 34'sd8191;
            5'd18:   v = 34'sd4095;
            5'd19:   v = 34'sd2047;
            5'd20:   v = 34'sd1023;
            5'd21:   v = 34'sd511;
            5'd22:   v = 34'sd255;
            5'd23:   v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q30 x Q30 -> Q30, floor
    function automatic trig_t mul30(input trig_t a, input trig_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p[61:30];
    endfunction

endpackage

FILE: src/tmc_angle_prep.sv
// Angle reduction: Q10.6 degrees to a folded magnitude in Q2.30 radians plus sign/fold flags.
// Depends on tmc_pkg.
module tmc_angle_prep
    import tmc_pkg::*;
(
    input  logic signed [15:0] angle,
    output cw_t                z,
    output fold_t              fold
);

    ang_t        a;
    ang_t        r1;
    ang_t        r2;
    ang_t        r3;
    ang_t        rn;
    logic [12:0] mag;
    logic [39:0] prod;

    always_comb
    begin
        a = {angle[15], angle};
        if (a >= FULL_TURN)
            r1 = a - FULL_TURN;
        else if (a <= -FULL_TURN)
            r1 = a + FULL_TURN;
        else
            r1 = a;

        if (r1 >= HALF_TURN)
            r2 = r1 - FULL_TURN;
        else if (r1 < -HALF_TURN)
            r2 = r1 + FULL_TURN;
        else
            r2 = r1;

        fold.flip = 1'b0;
        if (r2 > QUARTER_TURN)
        begin
            r3 = r2 - HALF_TURN;
            fold.flip = 1'b1;
        end
        else if (r2 < -QUARTER_TURN)
        begin
            r3 = r2 + HALF_TURN;
            fold.flip = 1'b1;
        end
        else
        begin
            r3 = r2;
        end

        fold.neg = r3[16];
        rn   = -r3;
        mag  = fold.neg ? rn[12:0] : r3[12:0];
        prod = 40'(mag) * DEG2RAD_Q32;
        z    = {2'b00, prod[39:8]};
    end

endmodule

FILE: src/tmc_cordic_cell.sv
// One CORDIC rotation step with its output register; cells chain into the sin/cos pipeline.
// Depends on tmc_pkg.
module tmc_cordic_cell
    import tmc_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [STEP_W-1:0] step,
    input  cw_t               x_in,
    input  cw_t               y_in,
    input  cw_t               z_in,
    output cw_t               x_out,
    output cw_t               y_out,
    output cw_t               z_out
);

    cw_t dx;
    cw_t dy;
    cw_t at;
    cw_t x_next;
    cw_t y_next;
    cw_t z_next;
    cw_t x_reg;
    cw_t y_reg;
    cw_t z_reg;

    always_comb
    begin
        dx = y_in >>> step;
        dy = x_in >>> step;
        at = atan_q30(step);
        if (!z_in[33])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - at;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

FILE: src/trs_model_matrix_compose.sv
// Model matrix composer, top level: T * Rz*Ry*Rx * S as the upper 3x4, Q16.16 out.
// Depends on tmc_pkg, tmc_angle_prep and tmc_cordic_cell.
//
// Fully pipelined: one beat in and one beat out per cycle while the output beat
// is not stalled. The pipeline has N_STEPS + 6 register stages, where N_STEPS is
// SINCOS_ITERATIONS capped at MAX_STEPS: one angle-reduction stage, one CORDIC
// cell per step for each of the three angles, a clamp and sign stage, two 32x32
// product stages, a sum stage and the scale/output stage.
// The whole pipeline holds while the output beat is stalled.
module trs_model_matrix_compose
    import tmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [23:0] scale_x,
    input  logic signed [23:0] scale_y,
    input  logic signed [23:0] scale_z,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] m00,
    output logic signed [31:0] m01,
    output logic signed [31:0] m02,
    output logic signed [31:0] m10,
    output logic signed [31:0] m11,
    output logic signed [31:0] m12,
    output logic signed [31:0] m20,
    output logic signed [31:0] m21,
    output logic signed [31:0] m22,
    output logic signed [31:0] tx,
    output logic signed [31:0] ty,
    output logic signed [31:0] tz
);

    logic              adv;
    logic [LAST:0]     vld_reg;
    side_t             side_reg [0:LAST];
    side_t             side_in;

    logic signed [15:0] ang [3];
    cw_t               zp [3];
    fold_t             fp [3];
    cw_t               z0_reg [3];

    cw_t               xw [3][N_STEPS+1];
    cw_t               yw [3][N_STEPS+1];
    cw_t               zw [3][N_STEPS+1];

    cw_t               xc [3];
    cw_t               yc [3];
    trig_t             s_next [3];
    trig_t             c_next [3];
    trig_t             s_reg [3];
    trig_t             c_reg [3];

    // product stage 1
    trig_t cycz_reg, cysz_reg, sxcy_reg, cxcy_reg, sxsy_reg, cxsy_reg;
    trig_t cxsz_reg, sxsz_reg, cxcz_reg, sxcz_reg, nsy_reg, cz_reg, sz_reg;
    // product stage 2
    trig_t a01_reg, a11_reg, a02_reg, a12_reg;
    trig_t cycz2_reg, cysz2_reg, sxcy2_reg, cxcy2_reg, nsy2_reg;
    trig_t cxsz2_reg, sxsz2_reg, cxcz2_reg, sxcz2_reg;

    rot_t              r_reg [9];
    logic signed [23:0] sc [3];
    logic signed [56:0] pr [9];
    logic signed [31:0] m_next [9];
    logic signed [31:0] m_reg [9];

    assign adv          = !(vld_reg[LAST] && result_stall);
    assign item_stall   = vld_reg[LAST] && result_stall;
    assign result_valid = vld_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAST-1:0], item_valid};
    end

    assign ang[0] = angle_x;
    assign ang[1] = angle_y;
    assign ang[2] = angle_z;

    genvar l, k;
    generate
        for (l = 0; l < 3; l++)
        begin : g_lane
            tmc_angle_prep u_prep (
                .angle (ang[l]),
                .z     (zp[l]),
                .fold  (fp[l])
            );

            assign xw[l][0] = CORDIC_GAIN;
            assign yw[l][0] = '0;
            assign zw[l][0] = z0_reg[l];

            for (k = 0; k < N_STEPS; k++)
            begin : g_cell
                tmc_cordic_cell u_cell (
                    .clk   (clk),
                    .en    (adv),
                    .step  (STEP_W'(k)),
                    .x_in  (xw[l][k]),
                    .y_in  (yw[l][k]),
                    .z_in  (zw[l][k]),
                    .x_out (xw[l][k+1]),
                    .y_out (yw[l][k+1]),
                    .z_out (zw[l][k+1])
                );
            end

            always_comb
            begin
                if (xw[l][N_STEPS] > ONE_Q30)
                    xc[l] = ONE_Q30;
                else if (xw[l][N_STEPS] < -ONE_Q30)
                    xc[l] = -ONE_Q30;
                else
                    xc[l] = xw[l][N_STEPS];
                if (yw[l][N_STEPS] > ONE_Q30)
                    yc[l] = ONE_Q30;
                else if (yw[l][N_STEPS] < -ONE_Q30)
                    yc[l] = -ONE_Q30;
                else
                    yc[l] = yw[l][N_STEPS];
                s_next[l] = yc[l][31:0];
                c_next[l] = xc[l][31:0];
                if (side_reg[N_STEPS].fold[l].neg)
                    s_next[l] = -s_next[l];
                if (side_reg[N_STEPS].fold[l].flip)
                begin
                    s_next[l] = -s_next[l];
                    c_next[l] = -c_next[l];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    z0_reg[l] <= zp[l];
                    s_reg[l]  <= s_next[l];
                    c_reg[l]  <= c_next[l];
                end
            end
        end
    endgenerate

    always_comb
    begin
        side_in.pos_x   = pos_x;
        side_in.pos_y   = pos_y;
        side_in.pos_z   = pos_z;
        side_in.scale_x = scale_x;
        side_in.scale_y = scale_y;
        side_in.scale_z = scale_z;
        side_in.fold[0] = fp[0];
        side_in.fold[1] = fp[1];
        side_in.fold[2] = fp[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i <= LAST; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // lanes: 0 = x, 1 = y, 2 = z
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cycz_reg <= mul30(c_reg[1], c_reg[2]);
            cysz_reg <= mul30(c_reg[1], s_reg[2]);
            sxcy_reg <= mul30(s_reg[0], c_reg[1]);
            cxcy_reg <= mul30(c_reg[0], c_reg[1]);
            sxsy_reg <= mul30(s_reg[0], s_reg[1]);
            cxsy_reg <= mul30(c_reg[0], s_reg[1]);
            cxsz_reg <= mul30(c_reg[0], s_reg[2]);
            sxsz_reg <= mul30(s_reg[0], s_reg[2]);
            cxcz_reg <= mul30(c_reg[0], c_reg[2]);
            sxcz_reg <= mul30(s_reg[0], c_reg[2]);
            nsy_reg  <= -s_reg[1];
            cz_reg   <= c_reg[2];
            sz_reg   <= s_reg[2];

            a01_reg   <= mul30(sxsy_reg, cz_reg);
            a11_reg   <= mul30(sxsy_reg, sz_reg);
            a02_reg   <= mul30(cxsy_reg, cz_reg);
            a12_reg   <= mul30(cxsy_reg, sz_reg);
            cycz2_reg <= cycz_reg;
            cysz2_reg <= cysz_reg;
            sxcy2_reg <= sxcy_reg;
            cxcy2_reg <= cxcy_reg;
            nsy2_reg  <= nsy_reg;
            cxsz2_reg <= cxsz_reg;
            sxsz2_reg <= sxsz_reg;
            cxcz2_reg <= cxcz_reg;
            sxcz2_reg <= sxcz_reg;

            r_reg[0] <= 33'(cycz2_reg);
            r_reg[1] <= 33'(a01_reg) - 33'(cxsz2_reg);
            r_reg[2] <= 33'(a02_reg) + 33'(sxsz2_reg);
            r_reg[3] <= 33'(cysz2_reg);
            r_reg[4] <= 33'(a11_reg) + 33'(cxcz2_reg);
            r_reg[5] <= 33'(a12_reg) - 33'(sxcz2_reg);
            r_reg[6] <= 33'(nsy2_reg);
            r_reg[7] <= 33'(sxcy2_reg);
            r_reg[8] <= 33'(cxcy2_reg);
        end
    end

    assign sc[0] = side_reg[LAST-1].scale_x;
    assign sc[1] = side_reg[LAST-1].scale_y;
    assign sc[2] = side_reg[LAST-1].scale_z;

    // |R| <= 2 and |scale| <= 2^7, so the Q16.16 result always fits in 32 bits and needs no clamp
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            pr[i]     = 57'(r_reg[i]) * 57'(sc[i % 3]);
            m_next[i] = 32'(pr[i] >>> 30);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 9; i++)
                m_reg[i] <= m_next[i];
        end
    end

    assign m00 = m_reg[0];
    assign m01 = m_reg[1];
    assign m02 = m_reg[2];
    assign m10 = m_reg[3];
    assign m11 = m_reg[4];
    assign m12 = m_reg[5];
    assign m20 = m_reg[6];
    assign m21 = m_reg[7];
    assign m22 = m_reg[8];
    assign tx  = side_reg[LAST].pos_x;
    assign ty  = side_reg[LAST].pos_y;
    assign tz  = side_reg[LAST].pos_z;

endmodule

FILE: verif/trs_model_matrix_compose_tb.sv
// Testbench for trs_model_matrix_compose: a table of directed transforms, then random ones,
// each checked against a fixed-point model of T*Rz*Ry*Rx*S. Depends on tmc_pkg and the RTL.
`timescale 1ns / 1ps

module trs_model_matrix_compose_tb;
    import tmc_pkg::*;

    localparam int N_RANDOM  = 1200;
    localparam int STALL_MAX = 20000;
    localparam int DRAIN     = N_STEPS + 20;

    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic signed [23:0] sx, sy, sz;
        logic signed [15:0] ax, ay, az;
    } xform_t;

    typedef struct packed {
        logic [11:0][31:0] m;
    } matrix_t;

    typedef struct {
        xform_t  xf;
        bit      has_exp;
        matrix_t exp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [23:0] scale_x = '0, scale_y = '0, scale_z = '0;
    logic signed [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, tx, ty, tz;

    matrix_t pending_matrices[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  timed_out = 1'b0;
    bit  quiet = 1'b0;

    trs_model_matrix_compose u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint floor_shr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return floor_shr(a * b, 30);
    endfunction

    function automatic void deg_sincos(input logic signed [15:0] a, output longint s,
                                       output longint c);
        longint r, x, y, z, dx, dy;
        bit flip, neg;
        r = longint'(a) % 23040;
        flip = 1'b0;
        if (r >= 11520) r -= 23040;
        if (r < -11520) r += 23040;
        if (r > 5760)
        begin
            r -= 11520;
            flip = 1'b1;
        end
        else if (r < -5760)
        begin
            r += 11520;
            flip = 1'b1;
        end
        neg = r < 0;
        if (neg) r = -r;
        z = (r * 74961321) >>> 8;
        x = 652032874;
        y = 0;
        for (int i = 0; i < N_STEPS; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_q30(i[4:0]));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_q30(i[4:0]));
            end
        end
        x = clip(x, -(64'sd1 << 30), 64'sd1 << 30);
        y = clip(y, -(64'sd1 << 30), 64'sd1 << 30);
        if (neg) y = -y;
        if (flip)
        begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic logic [31:0] scaled(longint r, logic signed [23:0] k);
        longint v;
        v = clip(floor_shr(r * longint'(k), 30), -(64'sd1 << 31), (64'sd1 << 31) - 1);
        return v[31:0];
    endfunction

    function automatic matrix_t compose_matrix(xform_t f);
        longint sx, cx, sy, cy, sz, cz;
        longint r[9];
        matrix_t o;
        deg_sincos(f.ax, sx, cx);
        deg_sincos(f.ay, sy, cy);
        deg_sincos(f.az, sz, cz);
        r[0] = q30_mul(cy, cz);
        r[1] = q30_mul(q30_mul(sx, sy), cz) - q30_mul(cx, sz);
        r[2] = q30_mul(q30_mul(cx, sy), cz) + q30_mul(sx, sz);
        r[3] = q30_mul(cy, sz);
        r[4] = q30_mul(q30_mul(sx, sy), sz) + q30_mul(cx, cz);
        r[5] = q30_mul(q30_mul(cx, sy), sz) - q30_mul(sx, cz);
        r[6] = -sy;
        r[7] = q30_mul(sx, cy);
        r[8] = q30_mul(cx, cy);
        for (int i = 0; i < 9; i++)
            o.m[11 - i] = scaled(r[i], i % 3 == 0 ? f.sx : (i % 3 == 1 ? f.sy : f.sz));
        o.m[2] = f.px;
        o.m[1] = f.py;
        o.m[0] = f.pz;
        return o;
    endfunction

    function automatic xform_t rand_xform();
        xform_t f;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        f = raw[215:0];
        case ($urandom_range(0, 3))
            0:
            begin
                f.sx = 24'(int'($urandom_range(0, 262144)) - 131072);
                f.sy = 24'(int'($urandom_range(0, 262144)) - 131072);
                f.sz = 24'(int'($urandom_range(0, 262144)) - 131072);
            end
            1:
            begin
                f.ax = 16'(int'($urandom_range(0, 46080)) - 23040);
                f.ay = 16'(int'($urandom_range(0, 46080)) - 23040);
                f.az = 16'(int'($urandom_range(0, 46080)) - 23040);
            end
            2:
            begin
                f.ax = 16'(90 * 64 * int'($urandom_range(0, 8)) - 23040);
                f.ay = 16'(90 * 64 * int'($urandom_range(0, 8)) - 23040);
                f.az = 16'(90 * 64 * int'($urandom_range(0, 8)) - 23040);
            end
            default: ;
        endcase
        return f;
    endfunction

    task automatic send_beat(input xform_t f, input bit gaps);
        while (gaps && $urandom_range(0, 99) < 12)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        {pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z} <= f;
        pending_matrices.push_back(compose_matrix(f));
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            result_stall <= !quiet && $urandom_range(0, 99) < 12;
    end

    always @(posedge clk)
    begin
        matrix_t got, want;
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && result_valid && !result_stall)
        begin
            got.m = {m00, m01, m02, m10, m11, m12, m20, m21, m22, tx, ty, tz};
            if (pending_matrices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end
            else
            begin
                want = pending_matrices.pop_front();
                for (int i = 0; i < 12; i++)
                    if (got.m[11 - i] !== want.m[11 - i])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("entry %0d: expected %h, actual %h",
                                     i, want.m[11 - i], got.m[11 - i]);
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_MAX && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    row_t rows[$];

    initial
    begin
        row_t rw;
        matrix_t m;
        logic [15:0] angs[10] = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd5760, -16'sd5760,
                                  16'sd11520, -16'sd11520, 16'sd23040, 16'sd17280, 16'sd1};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero angles, unit scale
        rw.xf = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 24'sh010000, 24'sh010000,
                  24'sh010000, 16'sd0, 16'sd0, 16'sd0};
        rw.has_exp = 1'b0;
        rows.push_back(rw);
        // zero scale zeroes every rotation entry
        rw.xf = '{32'sd1, -32'sd1, 32'sh12345678, 24'sd0, 24'sd0, 24'sd0,
                  16'sh7FFF, 16'sh8000, 16'sd2880};
        rw.has_exp = 1'b1;
        rw.exp.m = {{9{32'h0}}, 32'h1, 32'hFFFFFFFF, 32'h12345678};
        rows.push_back(rw);
        rw.has_exp = 1'b0;
        for (int i = 0; i < 10; i++)
        begin
            rw.xf = '{32'sd0, 32'sd0, 32'sd0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                      angs[i], angs[(i + 3) % 10], angs[(i + 7) % 10]};
            rows.push_back(rw);
        end
        for (int i = 0; i < 6; i++)
        begin
            rw.xf = '{32'sh7FFFFFFF, 32'sh80000000, 32'hFFFFFFFF, 24'sh800000,
                      24'sh800000, 24'sh800000, angs[i + 1], angs[i + 2], angs[i + 3]};
            rows.push_back(rw);
        end

        foreach (rows[i])
        begin
            m = compose_matrix(rows[i].xf);
            if (rows[i].has_exp && m !== rows[i].exp)
            begin
                mismatches++;
                if (mismatches <= 10) $display("row %0d: model %h typed %h", i, m, rows[i].exp);
            end
            if (rows[i].has_exp) pending_matrices.push_back(rows[i].exp);
            else pending_matrices.push_back(m);
            item_valid <= 1'b1;
            {pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z}
                <= rows[i].xf;
            @(posedge clk);
            while (item_stall) @(posedge clk);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 400)
            begin
                item_valid <= 1'b0;
                while (pending_matrices.size() != 0) @(posedge clk);
            end
            quiet = n >= 600 && n < 800;
            send_beat(rand_xform(), !quiet);
        end
        item_valid <= 1'b0;
        quiet = 1'b0;
        while (pending_matrices.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
